/* sv/mda_pkg.sv */
package mda_pkg;

  // Default capacity of each operand store, in decimal digits.
  localparam int unsigned MaxDigitsDef = 32;

  // Width of one decimal digit and of the command field.
  localparam int unsigned DigitW = 4;
  localparam int unsigned CmdW   = 2;

  // Decimal radix; a digit sum above RADIX - 1 wraps and carries.
  localparam int unsigned Radix = 10;

  typedef enum logic [CmdW-1:0] {
    CMD_PUSH_FIRST  = 2'd0,
    CMD_PUSH_SECOND = 2'd1,
    CMD_ADD         = 2'd2
  } cmd_e;

endpackage

/* sv/mda_if.sv */
// Request channel into the adder: a command and a digit to load.
interface mda_in_if import mda_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CmdW-1:0]   cmd;
  logic [DigitW-1:0] digit;

  modport source (output valid, output cmd, output digit, input ready);
  modport sink   (input valid, input cmd, input digit, output ready);
endinterface

// Result channel out of the adder: one sum digit per transfer.
interface mda_out_if import mda_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DigitW-1:0] sum_digit;
  logic              last;
  logic              dropped;

  modport source (output valid, output sum_digit, output last, output dropped, input ready);
  modport sink   (input valid, input sum_digit, input last, input dropped, output ready);
endinterface

/* sv/mda_ram.sv */
// Simple dual-port RAM: one write port, one read port with registered data.
module mda_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/msd_first_decimal_adder.sv */
// Decimal adder for numbers loaded most significant digit first.
//
// Requests arrive on in_i. A push request (first or second operand) writes
// one digit, saturated to nine, into that operand's digit memory. A digit
// pushed onto a full store is discarded and a sticky drop flag is set. An
// add request walks both operands from the least significant digit, one
// digit a cycle, with a ripple carry into the sum memory, and then settles
// the final carry. The sum is then read back most significant digit first
// onto out_o, each digit passing through a read state and an emit state and
// waiting while the receiver stalls. The final digit carries last, and
// every digit carries the drop flag as it stood when the add was requested.
// An empty add gives a single zero, and after an add both stores are empty.
//
// in_i.ready is high only while no add is in progress. out_o is driven from
// an output register, so a push may be taken while a digit waits there; when
// the receiver stalls, the read-back pauses until the register frees up.
// Reset clears the digit counts, the drop flag and the output valid; memory
// contents are left as they are and never read before they are written.
module msd_first_decimal_adder import mda_pkg::*; #(
  parameter int unsigned MAX_DIGITS = MaxDigitsDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  mda_in_if.sink   in_i,
  mda_out_if.source out_o
);

  // Operand address, digit count, sum address and emit counter widths.
  localparam int unsigned AW  = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int unsigned CW  = $clog2(MAX_DIGITS + 1);
  localparam int unsigned SAW = $clog2(MAX_DIGITS + 1);
  localparam int unsigned TW  = $clog2(MAX_DIGITS + 2);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ADD  = 5'b00010,
    S_FIN  = 5'b00100,
    S_ERD  = 5'b01000,
    S_EOUT = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [CW-1:0] first_cnt_q, first_cnt_d;
  logic [CW-1:0] second_cnt_q, second_cnt_d;
  logic          drop_q, drop_d;

  // Snapshot of the operands taken when an add request is accepted.
  logic [CW-1:0] a_cnt_q, a_cnt_d;
  logic [CW-1:0] b_cnt_q, b_cnt_d;
  logic [CW-1:0] len_q, len_d;
  logic          flag_q, flag_d;

  // Add pipeline: read issue position, then a write-back stage in the following cycle.
  logic [CW-1:0] pos_q, pos_d;
  logic          rd_v_q, rd_v_d;
  logic          a_in_q, a_in_d;
  logic          b_in_q, b_in_d;
  logic [CW-1:0] wpos_q, wpos_d;
  logic          carry_q, carry_d;

  // Digits still to emit.
  logic [TW-1:0] rem_q, rem_d;

  logic              out_valid_q, out_valid_d;
  logic [DigitW-1:0] out_digit_q, out_digit_d;
  logic              out_last_q, out_last_d;
  logic              out_drop_q, out_drop_d;

  // Memory ports.
  logic              a_we, b_we, s_we;
  logic [AW-1:0]     a_waddr, b_waddr, a_raddr, b_raddr;
  logic [DigitW-1:0] push_digit;
  logic [DigitW-1:0] a_rdata, b_rdata, s_rdata, s_wdata;
  logic [SAW-1:0]    s_waddr, s_raddr;

  logic              in_fire;
  logic              out_free;
  logic [CW-1:0]     a_idx, b_idx;
  logic [DigitW:0]   dsum;
  logic [DigitW-1:0] a_term, b_term;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  assign push_digit = (in_i.digit > DigitW'(Radix - 1)) ? DigitW'(Radix - 1) : in_i.digit;

  // Position counted from the least significant end maps to store index
  // count - 1 - pos, since digits were stored in arrival order.
  assign a_idx   = a_cnt_q - CW'(1) - pos_q;
  assign b_idx   = b_cnt_q - CW'(1) - pos_q;
  assign a_raddr = a_idx[AW-1:0];
  assign b_raddr = b_idx[AW-1:0];
  assign a_waddr = first_cnt_q[AW-1:0];
  assign b_waddr = second_cnt_q[AW-1:0];

  assign a_term = a_in_q ? a_rdata : '0;
  assign b_term = b_in_q ? b_rdata : '0;
  assign dsum   = {1'b0, a_term} + {1'b0, b_term} + {{DigitW{1'b0}}, carry_q};

  // The sum memory is read at total - 1 - i, which is rem - 1.
  assign s_raddr = SAW'(rem_q - TW'(1));

  always_comb begin
    state_d      = state_q;
    first_cnt_d  = first_cnt_q;
    second_cnt_d = second_cnt_q;
    drop_d       = drop_q;
    a_cnt_d      = a_cnt_q;
    b_cnt_d      = b_cnt_q;
    len_d        = len_q;
    flag_d       = flag_q;
    pos_d        = pos_q;
    rd_v_d       = 1'b0;
    a_in_d       = a_in_q;
    b_in_d       = b_in_q;
    wpos_d       = wpos_q;
    carry_d      = carry_q;
    rem_d        = rem_q;
    out_valid_d  = out_valid_q;
    out_digit_d  = out_digit_q;
    out_last_d   = out_last_q;
    out_drop_d   = out_drop_q;
    a_we         = 1'b0;
    b_we         = 1'b0;
    s_we         = 1'b0;
    s_waddr      = wpos_q[SAW-1:0];
    s_wdata      = dsum[DigitW-1:0];

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          case (in_i.cmd)
            CMD_PUSH_FIRST: begin
              if (first_cnt_q < CW'(MAX_DIGITS)) begin
                a_we        = 1'b1;
                first_cnt_d = first_cnt_q + CW'(1);
              end else begin
                drop_d = 1'b1;
              end
            end
            CMD_PUSH_SECOND: begin
              if (second_cnt_q < CW'(MAX_DIGITS)) begin
                b_we         = 1'b1;
                second_cnt_d = second_cnt_q + CW'(1);
              end else begin
                drop_d = 1'b1;
              end
            end
            CMD_ADD: begin
              a_cnt_d      = first_cnt_q;
              b_cnt_d      = second_cnt_q;
              len_d        = (first_cnt_q > second_cnt_q) ? first_cnt_q : second_cnt_q;
              flag_d       = drop_q;
              first_cnt_d  = '0;
              second_cnt_d = '0;
              drop_d       = 1'b0;
              pos_d        = '0;
              carry_d      = 1'b0;
              state_d      = S_ADD;
            end
            default: begin
            end
          endcase
        end
      end

      S_ADD: begin
        // Write-back of the digit read in the previous cycle.
        if (rd_v_q) begin
          s_we = 1'b1;
          if (dsum > (DigitW + 1)'(Radix - 1)) begin
            s_wdata = DigitW'(dsum - (DigitW + 1)'(Radix));
            carry_d = 1'b1;
          end else begin
            carry_d = 1'b0;
          end
        end
        // Read issue for the next position.
        if (pos_q < len_q) begin
          rd_v_d = 1'b1;
          a_in_d = pos_q < a_cnt_q;
          b_in_d = pos_q < b_cnt_q;
          wpos_d = pos_q;
          pos_d  = pos_q + CW'(1);
        end else if (!rd_v_q) begin
          state_d = S_FIN;
        end
      end

      S_FIN: begin
        // A remaining carry becomes the leading 1; an empty add gives one zero.
        s_waddr = len_q[SAW-1:0];
        s_wdata = {{(DigitW - 1){1'b0}}, carry_q};
        s_we    = carry_q || (len_q == '0);
        if (len_q == '0) begin
          rem_d = TW'(1);
        end else begin
          rem_d = TW'(len_q) + TW'(carry_q);
        end
        state_d = S_ERD;
      end

      S_ERD: begin
        state_d = S_EOUT;
      end

      S_EOUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_digit_d = s_rdata;
          out_last_d  = (rem_q == TW'(1));
          out_drop_d  = flag_q;
          rem_d       = rem_q - TW'(1);
          state_d     = (rem_q == TW'(1)) ? S_IDLE : S_ERD;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      first_cnt_q  <= '0;
      second_cnt_q <= '0;
      drop_q       <= 1'b0;
      rd_v_q       <= 1'b0;
      carry_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      first_cnt_q  <= first_cnt_d;
      second_cnt_q <= second_cnt_d;
      drop_q       <= drop_d;
      rd_v_q       <= rd_v_d;
      carry_q      <= carry_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_cnt_q     <= a_cnt_d;
    b_cnt_q     <= b_cnt_d;
    len_q       <= len_d;
    flag_q      <= flag_d;
    pos_q       <= pos_d;
    a_in_q      <= a_in_d;
    b_in_q      <= b_in_d;
    wpos_q      <= wpos_d;
    rem_q       <= rem_d;
    out_digit_q <= out_digit_d;
    out_last_q  <= out_last_d;
    out_drop_q  <= out_drop_d;
  end

  mda_ram #(
    .WIDTH (DigitW),
    .DEPTH (MAX_DIGITS)
  ) u_first_ram (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (a_waddr),
    .wdata_i (push_digit),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  mda_ram #(
    .WIDTH (DigitW),
    .DEPTH (MAX_DIGITS)
  ) u_second_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (b_waddr),
    .wdata_i (push_digit),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  mda_ram #(
    .WIDTH (DigitW),
    .DEPTH (MAX_DIGITS + 1)
  ) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  assign out_o.valid     = out_valid_q;
  assign out_o.sum_digit = out_digit_q;
  assign out_o.last      = out_last_q;
  assign out_o.dropped   = out_drop_q;

  // The add pipeline has drained before the final carry is resolved.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN) |-> !rd_v_q)
    else $error("sum write-back still pending at finish");

  // The read position never runs past the longer operand.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ADD) |-> (pos_q <= len_q))
    else $error("add position beyond operand length");

  // While emitting, at least one and at most MAX_DIGITS + 1 digits remain.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ERD || state_q == S_EOUT) |->
      (rem_q != '0 && rem_q <= TW'(MAX_DIGITS + 1)))
    else $error("emit count out of range");

  // A digit marked last always returns the block to accepting requests.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EOUT && out_free && rem_q == TW'(1)) |=>
      (state_q == S_IDLE && out_valid_q && out_last_q))
    else $error("final digit did not end the add");

endmodule
